// ===== src/cgtg_pkg.sv =====
// ----------------------------------------------------------------------------
// cgtg_pkg
// Shared types, constants and helpers of the colour gradient table generator.
// ----------------------------------------------------------------------------
package cgtg_pkg;

  localparam int TABLE_ENTRIES = 32;

  localparam int COLOUR_W = 12;
  localparam int COUNT_W  = 8;
  localparam int LINE_W   = 8;
  localparam int INDEX_W  = 6;
  localparam int LEN_W    = 7;
  localparam int NIB_W    = 4;
  localparam int DIVS_W   = 6;
  localparam int NUM_COMP = 3;

  localparam logic [LINE_W-1:0] LAST_LINE = 8'd199;

  typedef enum logic [1:0] {
    SEL_LINE,
    SEL_GREEN,
    SEL_RED,
    SEL_BLUE
  } div_sel_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_e div_sel;
    logic     emit;
  } cgtg_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
    logic last;
  } cgtg_sts_t;

  function automatic div_sel_e next_sel(input div_sel_e sel);
    div_sel_e res;
    unique case (sel)
      SEL_LINE:  res = SEL_GREEN;
      SEL_GREEN: res = SEL_RED;
      SEL_RED:   res = SEL_BLUE;
      SEL_BLUE:  res = SEL_LINE;
      default:   res = SEL_LINE;
    endcase
    return res;
  endfunction

endpackage

// ===== src/cgtg_req_if.sv =====
// ----------------------------------------------------------------------------
// cgtg_req_if
// Request channel: two colours and an entry count, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cgtg_req_if;
  logic                              valid;
  logic                              ready;
  logic [cgtg_pkg::COLOUR_W-1:0]     start_colour;
  logic [cgtg_pkg::COLOUR_W-1:0]     end_colour;
  logic [cgtg_pkg::COUNT_W-1:0]      entry_count;

  modport source(output valid, start_colour, end_colour, entry_count, input ready);
  modport sink(input valid, start_colour, end_colour, entry_count, output ready);
endinterface

// ===== src/cgtg_ent_if.sv =====
// ----------------------------------------------------------------------------
// cgtg_ent_if
// Entry channel: one raster table entry per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cgtg_ent_if;
  logic                              valid;
  logic                              ready;
  logic [cgtg_pkg::LINE_W-1:0]       line_number;
  logic [cgtg_pkg::COLOUR_W-1:0]     entry_colour;
  logic [cgtg_pkg::INDEX_W-1:0]      entry_index;
  logic                              last_entry;

  modport source(output valid, line_number, entry_colour, entry_index, last_entry,
                 input ready);
  modport sink(input valid, line_number, entry_colour, entry_index, last_entry,
               output ready);
endinterface

// ===== src/colour_gradient_table_generator.sv =====
// ----------------------------------------------------------------------------
// colour_gradient_table_generator
// Builds a linear colour ramp table from two 4-4-4 colours and an entry count.
// ----------------------------------------------------------------------------
// req_i carries start_colour, end_colour and entry_count; a count of zero or
// above the table size selects the full table. ent_o delivers one entry per
// transfer: line_number, entry_colour, entry_index and last_entry, which is
// set on the final entry of the run.
// One request is handled at a time; req_i.ready is high only while idle.
// After a request transfer the block runs four divisions on a shared
// one-bit-per-cycle divider (line step, then green, red and blue increments),
// each in turn, and the first entry follows once the blue one is done.
// Entries then follow one per cycle from remainder accumulators while the
// receiver keeps taking them. The output register holds an entry while the
// receiver stalls and the run pauses until it is taken; the next request is
// taken as soon as the last entry is in the output register.
// Reset empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module colour_gradient_table_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  cgtg_req_if.sink    req_i,
  cgtg_ent_if.source  ent_o
);

  cgtg_pkg::cgtg_cmd_t cmd;
  cgtg_pkg::cgtg_sts_t sts;
  logic                req_ready;

  cgtg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cgtg_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .ent_o  (ent_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  assign req_i.ready = req_ready;

endmodule

// ===== src/cgtg_div.sv =====
// ----------------------------------------------------------------------------
// cgtg_div
// Restoring divider, one quotient bit per cycle, 8-bit dividend by 6-bit
// divisor. The divisor is read during the steps and must stay stable.
// ----------------------------------------------------------------------------
module cgtg_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [cgtg_pkg::LINE_W-1:0]  dividend_i,
  input  logic [cgtg_pkg::DIVS_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [cgtg_pkg::LINE_W-1:0]  quotient_o,
  output logic [cgtg_pkg::DIVS_W-1:0]  remainder_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [2:0]                    cnt_q;
  logic [cgtg_pkg::LINE_W-1:0]   quo_q;
  logic [cgtg_pkg::DIVS_W-1:0]   rem_q;
  logic [cgtg_pkg::DIVS_W:0]     shifted;
  logic                          fits;
  logic [cgtg_pkg::DIVS_W:0]     diff;

  assign shifted = {rem_q, quo_q[cgtg_pkg::LINE_W-1]};
  assign fits    = shifted >= {1'b0, divisor_i};
  assign diff    = shifted - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[cgtg_pkg::LINE_W-2:0], fits};
      rem_q <= fits ? diff[cgtg_pkg::DIVS_W-1:0] : shifted[cgtg_pkg::DIVS_W-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== src/cgtg_datapath.sv =====
// ----------------------------------------------------------------------------
// cgtg_datapath
// Request latch, setup divisions, per-entry colour and line accumulators and
// the output register.
// ----------------------------------------------------------------------------
module cgtg_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cgtg_req_if.sink              req_i,
  cgtg_ent_if.source            ent_o,
  input  cgtg_pkg::cgtg_cmd_t   cmd_i,
  output cgtg_pkg::cgtg_sts_t   sts_o
);

  localparam int NW = cgtg_pkg::NIB_W;
  localparam int NC = cgtg_pkg::NUM_COMP;

  logic [cgtg_pkg::COLOUR_W-1:0] start_q;
  logic [cgtg_pkg::COLOUR_W-1:0] end_q;
  logic [cgtg_pkg::LEN_W-1:0]    len_q;
  logic [cgtg_pkg::DIVS_W-1:0]   divs_q;
  logic [cgtg_pkg::LINE_W-1:0]   step_q;
  logic [cgtg_pkg::INDEX_W-1:0]  idx_q;
  logic [cgtg_pkg::LINE_W-1:0]   line_q;
  cgtg_pkg::div_sel_e            sel_q;
  logic [NW-1:0]                 qinc_q [NC];
  logic [NW-1:0]                 acc_q  [NC];
  logic [cgtg_pkg::DIVS_W-1:0]   rinc_q [NC];
  logic [cgtg_pkg::DIVS_W-1:0]   rem_q  [NC];

  logic [cgtg_pkg::LEN_W-1:0]    len_d;
  logic [cgtg_pkg::DIVS_W-1:0]   divs_d;
  logic [NW-1:0]                 mag    [NC];
  logic                          neg    [NC];
  logic [NW-1:0]                 nib    [NC];
  logic [cgtg_pkg::DIVS_W:0]     rsum   [NC];
  logic                          wrap   [NC];
  logic [NW-1:0]                 acc_d  [NC];
  logic [cgtg_pkg::DIVS_W-1:0]   rem_d  [NC];
  logic [cgtg_pkg::LINE_W-1:0]   dividend;
  logic                          div_done;
  logic [cgtg_pkg::LINE_W-1:0]   quotient;
  logic [cgtg_pkg::DIVS_W-1:0]   remainder;

  logic                          ent_valid_q;
  logic [cgtg_pkg::LINE_W-1:0]   ent_line_q;
  logic [cgtg_pkg::COLOUR_W-1:0] ent_colour_q;
  logic [cgtg_pkg::INDEX_W-1:0]  ent_index_q;
  logic                          ent_last_q;
  logic                          last;

  always_comb begin
    if (req_i.entry_count == '0 ||
        req_i.entry_count > cgtg_pkg::COUNT_W'(cgtg_pkg::TABLE_ENTRIES)) begin
      len_d = cgtg_pkg::LEN_W'(cgtg_pkg::TABLE_ENTRIES);
    end else begin
      len_d = req_i.entry_count[cgtg_pkg::LEN_W-1:0];
    end
    if (len_d > cgtg_pkg::LEN_W'(1)) begin
      divs_d = cgtg_pkg::DIVS_W'(len_d - cgtg_pkg::LEN_W'(1));
    end else begin
      divs_d = cgtg_pkg::DIVS_W'(1);
    end
  end

  // component 0 is blue, 1 red, 2 green
  always_comb begin
    for (int k = 0; k < NC; k++) begin
      neg[k]  = end_q[k*NW +: NW] < start_q[k*NW +: NW];
      mag[k]  = neg[k] ? start_q[k*NW +: NW] - end_q[k*NW +: NW]
                       : end_q[k*NW +: NW] - start_q[k*NW +: NW];
      nib[k]  = neg[k] ? start_q[k*NW +: NW] - acc_q[k]
                       : start_q[k*NW +: NW] + acc_q[k];
      rsum[k] = {1'b0, rem_q[k]} + {1'b0, rinc_q[k]};
      wrap[k] = rsum[k] >= {1'b0, divs_q};
      rem_d[k] = wrap[k] ? cgtg_pkg::DIVS_W'(rsum[k] - {1'b0, divs_q})
                         : rsum[k][cgtg_pkg::DIVS_W-1:0];
      acc_d[k] = acc_q[k] + qinc_q[k] + {{(NW-1){1'b0}}, wrap[k]};
    end
  end

  always_comb begin
    unique case (cmd_i.div_sel)
      cgtg_pkg::SEL_LINE:  dividend = cgtg_pkg::LAST_LINE;
      cgtg_pkg::SEL_GREEN: dividend = cgtg_pkg::LINE_W'(mag[2]);
      cgtg_pkg::SEL_RED:   dividend = cgtg_pkg::LINE_W'(mag[1]);
      cgtg_pkg::SEL_BLUE:  dividend = cgtg_pkg::LINE_W'(mag[0]);
      default:             dividend = cgtg_pkg::LAST_LINE;
    endcase
  end

  cgtg_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (dividend),
    .divisor_i   (divs_q),
    .done_o      (div_done),
    .quotient_o  (quotient),
    .remainder_o (remainder)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      start_q <= req_i.start_colour;
      end_q   <= req_i.end_colour;
      len_q   <= len_d;
      divs_q  <= divs_d;
      idx_q   <= '0;
      line_q  <= '0;
      for (int k = 0; k < NC; k++) begin
        acc_q[k] <= '0;
        rem_q[k] <= '0;
      end
    end else if (cmd_i.emit) begin
      idx_q  <= idx_q + cgtg_pkg::INDEX_W'(1);
      line_q <= line_q + step_q;
      for (int k = 0; k < NC; k++) begin
        acc_q[k] <= acc_d[k];
        rem_q[k] <= rem_d[k];
      end
    end
    if (cmd_i.div_start) begin
      sel_q <= cmd_i.div_sel;
    end
    if (div_done) begin
      unique case (sel_q)
        cgtg_pkg::SEL_LINE: begin
          step_q <= quotient;
        end
        cgtg_pkg::SEL_GREEN: begin
          qinc_q[2] <= quotient[NW-1:0];
          rinc_q[2] <= remainder;
        end
        cgtg_pkg::SEL_RED: begin
          qinc_q[1] <= quotient[NW-1:0];
          rinc_q[1] <= remainder;
        end
        cgtg_pkg::SEL_BLUE: begin
          qinc_q[0] <= quotient[NW-1:0];
          rinc_q[0] <= remainder;
        end
        default: begin
          step_q <= quotient;
        end
      endcase
    end
  end

  assign last = ({1'b0, idx_q} + cgtg_pkg::LEN_W'(1)) == len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ent_valid_q <= 1'b1;
    end else if (ent_o.ready) begin
      ent_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      ent_line_q   <= line_q;
      ent_colour_q <= {nib[2], nib[1], nib[0]};
      ent_index_q  <= idx_q;
      ent_last_q   <= last;
    end
  end

  assign ent_o.valid        = ent_valid_q;
  assign ent_o.line_number  = ent_line_q;
  assign ent_o.entry_colour = ent_colour_q;
  assign ent_o.entry_index  = ent_index_q;
  assign ent_o.last_entry   = ent_last_q;

  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !ent_valid_q || ent_o.ready;
  assign sts_o.last     = last;

endmodule

// ===== src/cgtg_ctrl.sv =====
// ----------------------------------------------------------------------------
// cgtg_ctrl
// Sequencer: accept a request, run the four setup divisions, then step the
// entry run into the output register.
// ----------------------------------------------------------------------------
module cgtg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  cgtg_pkg::cgtg_sts_t   sts_i,
  output cgtg_pkg::cgtg_cmd_t   cmd_o
);

  cgtg_pkg::ctrl_state_e state_q, state_d;
  cgtg_pkg::div_sel_e    sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cgtg_pkg::ST_IDLE;
      sel_q   <= cgtg_pkg::SEL_LINE;
    end else begin
      state_q <= state_d;
      if (cmd_o.div_start) begin
        sel_q <= cmd_o.div_sel;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cgtg_pkg::ST_IDLE: begin
        if (req_valid_i) state_d = cgtg_pkg::ST_DIVIDE;
      end
      cgtg_pkg::ST_DIVIDE: begin
        if (sts_i.div_done && sel_q == cgtg_pkg::SEL_BLUE) state_d = cgtg_pkg::ST_EMIT;
      end
      cgtg_pkg::ST_EMIT: begin
        if (sts_i.out_free && sts_i.last) state_d = cgtg_pkg::ST_IDLE;
      end
      default: state_d = cgtg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o     = 1'b0;
    cmd_o.load      = 1'b0;
    cmd_o.div_start = 1'b0;
    cmd_o.div_sel   = sel_q;
    cmd_o.emit      = 1'b0;
    unique case (state_q)
      cgtg_pkg::ST_IDLE: begin
        req_ready_o     = 1'b1;
        cmd_o.load      = req_valid_i;
        cmd_o.div_start = req_valid_i;
        cmd_o.div_sel   = cgtg_pkg::SEL_LINE;
      end
      cgtg_pkg::ST_DIVIDE: begin
        if (sts_i.div_done && sel_q != cgtg_pkg::SEL_BLUE) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = cgtg_pkg::next_sel(sel_q);
        end
      end
      cgtg_pkg::ST_EMIT: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== sim/tb_colour_gradient_table_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_colour_gradient_table_generator
// Self-checking bench for the colour ramp table generator.
// ----------------------------------------------------------------------------
// Requests go in through the req_i channel, first a directed set around the
// count clamps, the single-entry run and the colour extremes, then random
// requests. A scoreboard expands each accepted request into the ramp entries
// it should produce and compares every entry transfer on ent_o field by
// field. Sender gaps and receiver stalls change from phase to phase. One
// phase holds the receiver off for a long stretch while requests keep
// coming. A watchdog ends the run if transfers stop.
// ----------------------------------------------------------------------------
module tb_colour_gradient_table_generator;
  import cgtg_pkg::*;

  localparam int IDLE_LIMIT      = 3000;
  localparam int SETTLE_CYCLES   = 80;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PCT_BUSY        = 84;
  localparam int PCT_BOTH        = 23;
  localparam int PHASE_ITEMS     = 40;
  localparam int MAX_GAP         = 200;

  typedef struct packed {
    logic [LINE_W-1:0]   line_number;
    logic [COLOUR_W-1:0] entry_colour;
    logic [INDEX_W-1:0]  entry_index;
    logic                last_entry;
  } ramp_entry_t;

  class ramp_checker;
    ramp_entry_t expected_q[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    function logic [NIB_W-1:0] mix_component(int from, int to, int i, int span);
      return NIB_W'(from + ((to - from) * i) / span);
    endfunction

    function void take_request(logic [COLOUR_W-1:0] s, logic [COLOUR_W-1:0] e,
                               logic [COUNT_W-1:0] cnt);
      int          n;
      int          span;
      int          step;
      ramp_entry_t ent;
      n = int'(cnt);
      if (n == 0 || n > TABLE_ENTRIES) begin
        n = TABLE_ENTRIES;
      end
      span = (n > 1) ? n - 1 : 1;
      step = (n > 1) ? int'(LAST_LINE) / span : 0;
      for (int i = 0; i < n; i++) begin
        ent.line_number = LINE_W'(i * step);
        for (int c = 0; c < NUM_COMP; c++) begin
          ent.entry_colour[c*NIB_W +: NIB_W] =
            mix_component(int'(s[c*NIB_W +: NIB_W]), int'(e[c*NIB_W +: NIB_W]), i, span);
        end
        ent.entry_index = INDEX_W'(i);
        ent.last_entry  = (i == n - 1);
        expected_q.push_back(ent);
      end
    endfunction

    function void check_entry(ramp_entry_t got);
      ramp_entry_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected entry: line_number %0d entry_colour %03h entry_index %0d last_entry %0d",
               got.line_number, got.entry_colour, got.entry_index, got.last_entry);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.line_number != want.line_number) begin
        $error("line_number: expected %0d, actual %0d", want.line_number, got.line_number);
        errors++;
      end
      if (got.entry_colour != want.entry_colour) begin
        $error("entry_colour: expected %03h, actual %03h", want.entry_colour, got.entry_colour);
        errors++;
      end
      if (got.entry_index != want.entry_index) begin
        $error("entry_index: expected %0d, actual %0d", want.entry_index, got.entry_index);
        errors++;
      end
      if (got.last_entry != want.last_entry) begin
        $error("last_entry: expected %0d, actual %0d", want.last_entry, got.last_entry);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_off_req;
  int          idle_cycles;
  ramp_checker board;

  cgtg_req_if req_if();
  cgtg_ent_if ent_if();

  colour_gradient_table_generator u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .ent_o  (ent_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver side: random stalls plus an occasional long hold-off
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    ent_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        ent_if.ready <= 1'b0;
        hold_left--;
      end else begin
        ent_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : monitor
    bit          moved;
    ramp_entry_t got;
    if (rst_n) begin
      moved = 1'b0;
      if (req_if.valid && req_if.ready) begin
        board.take_request(req_if.start_colour, req_if.end_colour, req_if.entry_count);
        moved = 1'b1;
      end
      if (ent_if.valid && ent_if.ready) begin
        got.line_number  = ent_if.line_number;
        got.entry_colour = ent_if.entry_colour;
        got.entry_index  = ent_if.entry_index;
        got.last_entry   = ent_if.last_entry;
        board.check_entry(got);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [COLOUR_W-1:0] s, input logic [COLOUR_W-1:0] e,
                              input logic [COUNT_W-1:0] cnt);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.start_colour <= s;
    req_if.end_colour   <= e;
    req_if.entry_count  <= cnt;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
  endtask

  task automatic send_random_request();
    logic [COUNT_W-1:0] cnt;
    case ($urandom_range(0, 9))
      0:       cnt = '0;
      1:       cnt = COUNT_W'($urandom_range(TABLE_ENTRIES + 1, 255));
      2, 3, 4: cnt = COUNT_W'($urandom_range(1, 4));
      default: cnt = COUNT_W'($urandom_range(1, TABLE_ENTRIES));
    endcase
    send_request(COLOUR_W'($urandom), COLOUR_W'($urandom), cnt);
  endtask

  // drop valid and hold until every expected entry has been taken
  task automatic wait_for_drain();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) send_random_request();
    wait_for_drain();
  endtask

  initial begin
    board               = new();
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    hold_off_req        = 1'b0;
    idle_cycles         = 0;
    rst_n               = 1'b0;
    req_if.valid        = 1'b0;
    req_if.start_colour = '0;
    req_if.end_colour   = '0;
    req_if.entry_count  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_request(12'h000, 12'hFFF, 8'd32);
    send_request(12'hFFF, 12'h000, 8'd32);
    send_request(12'hF0F, 12'h0F0, 8'd0);
    send_request(12'h0F0, 12'hF0F, 8'd1);
    send_request(12'hFFF, 12'h000, 8'd1);
    send_request(12'h123, 12'h321, 8'd2);
    send_request(12'hFFF, 12'hFFF, 8'd33);
    send_request(12'h000, 12'h000, 8'd255);
    send_request(12'hA5C, 12'h3E7, 8'd31);
    send_request(12'h5A3, 12'hC18, 8'd3);
    send_request(12'h0F0, 12'hF00, 8'd128);
    send_request(12'h00F, 12'hFF0, 8'd64);
    send_request(12'h777, 12'h888, 8'd16);
    send_request(12'h8E1, 12'h17E, 8'd4);
    wait_for_drain();

    run_phase(0, 0);
    run_phase(PCT_BUSY, 0);

    // long receiver hold-off while requests keep coming
    hold_off_req   = 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (4) send_random_request();
    wait_for_drain();

    run_phase(0, PCT_BUSY);
    run_phase(PCT_BOTH, PCT_BOTH);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/cgtg_pkg.sv
src/cgtg_req_if.sv
src/cgtg_ent_if.sv
src/cgtg_div.sv
src/cgtg_datapath.sv
src/cgtg_ctrl.sv
src/colour_gradient_table_generator.sv
sim/tb_colour_gradient_table_generator.sv
